@@ rtl/ddo_pkg.sv @@
// Package for the differential-drive odometry block: beat types, register
// indexes and reset values, sequencer states, CORDIC constants and control, and rounding helper.
// No dependencies.
package ddo_pkg;

    // Input beat: raw wheel tick rates
    typedef struct packed {
        logic signed [15:0] left_tick_rate;
        logic signed [15:0] right_tick_rate;
    } t_in_beat;

    // Output beat: pose and filtered rates
    typedef struct packed {
        logic signed [47:0] pose_x;
        logic signed [47:0] pose_y;
        logic signed [31:0] heading;
        logic signed [31:0] smoothed_left;
        logic signed [31:0] smoothed_right;
    } t_out_beat;

    // Configuration register indexes
    localparam logic [7:0] CFG_FILTER_GAIN   = 8'd0;
    localparam logic [7:0] CFG_LINEAR_SCALE  = 8'd1;
    localparam logic [7:0] CFG_ANGULAR_SCALE = 8'd2;

    // Register reset values
    localparam logic [15:0] GAIN_RST = 16'd45875;
    localparam logic [23:0] LIN_RST  = 24'd343395;
    localparam logic [23:0] ANG_RST  = 24'd1457410;

    // CORDIC constants
    localparam int          ATAN_ENTRIES = 30;
    localparam int          CNT_W        = 5;
    localparam logic [31:0] CORDIC_K_Q28 = 32'd163008219;
    localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE, S_FILT_L, S_FILT_R, S_SUM, S_DIST, S_CORD,
        S_DX, S_DY, S_DH, S_HEAD, S_OUT
    } t_state;

    // CORDIC control from sequencer
    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } t_cordic_ctl;

    // Round half up of p / 2^s
    function automatic logic signed [63:0] round_shift(
        input logic signed [63:0] p,
        input int                 s
    );
        logic signed [63:0] bias;
        bias = 64'sd1 <<< (s - 1);
        return (p + bias) >>> s;
    endfunction

endpackage

@@ rtl/ddo_mul.sv @@
// Shared signed multiplier with registered product.
// Depends on nothing.
module ddo_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [30:0] i_b,
    output logic signed [63:0] o_prod
);
    logic signed [63:0] r_prod;

    // one multiply per cycle, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a * i_b);
    end

    assign o_prod = r_prod;
endmodule

@@ rtl/ddo_cordic.sv @@
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
// Depends on ddo_pkg.
module ddo_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ddo_pkg::t_cordic_ctl       i_ctl,
    output logic                       o_busy,
    output logic signed [31:0]         o_cos,
    output logic signed [31:0]         o_sin
);
    import ddo_pkg::*;

    localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic signed [31:0] r_x, r_y, r_z;
    logic               r_flip, r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [31:0]        fold_sum, z0;
    logic signed [31:0] xs, ys;

    // fold heading into [-1/4, 1/4) turn
    always_comb begin
        fold_sum = i_ctl.angle + 32'h4000_0000;
        z0       = fold_sum[31] ? (i_ctl.angle + 32'h8000_0000) : i_ctl.angle;
    end

    assign xs = r_x >>> r_cnt;
    assign ys = r_y >>> r_cnt;

    // control: busy flag and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // vector rotation datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x    <= CORDIC_K_Q28;
            r_y    <= '0;
            r_z    <= z0;
            r_flip <= fold_sum[31];
        end else if (r_busy) begin
            if (!r_z[31]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - ATAN_TAB[r_cnt];
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + ATAN_TAB[r_cnt];
            end
        end
    end

    assign o_busy = r_busy;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;
endmodule

@@ rtl/diff_drive_odometry.sv @@
// Top level of the differential-drive odometry block: sequencer, state and I/O.
// Depends on ddo_pkg, ddo_mul, ddo_cordic.
//
// channel | direction | handshake              | payload
// --------+-----------+------------------------+---------------------------
// in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_beat)
// out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_beat)
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each beat takes the CORDIC iterations plus six passes through the shared
// multiplier. o_in_stall is high from accept until the result is loaded into
// the output register; a stalled output beat holds, delays the next load and
// keeps o_in_stall high. Reset clears pose, filters and heading and restores
// register defaults.
module diff_drive_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ddo_pkg::t_in_beat  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ddo_pkg::t_out_beat o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_index,
    input  logic [23:0]       i_cfg_data
);
    import ddo_pkg::*;

    t_state r_state, n_state;

    logic [15:0]        r_gain;
    logic [23:0]        r_lin, r_ang;
    logic signed [15:0] r_raw_l, r_raw_r;
    logic signed [31:0] r_fl, r_fr, r_head;
    logic signed [47:0] r_px, r_py;
    logic signed [32:0] r_d;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic signed [32:0] mul_a;
    logic signed [30:0] mul_b;
    logic signed [63:0] prod;
    logic signed [63:0] rnd16, rnd24, rnd28;
    logic signed [31:0] cos_v, sin_v;
    logic               cordic_busy;
    t_cordic_ctl        cordic_ctl;
    logic               out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    ddo_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cordic_ctl),
        .o_busy  (cordic_busy),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    assign rnd16 = round_shift(prod, 16);
    assign rnd24 = round_shift(prod, 24);
    assign rnd28 = round_shift(prod, 28);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and multiplier operand select
    always_comb begin
        n_state          = r_state;
        mul_a            = '0;
        mul_b            = '0;
        cordic_ctl.start = 1'b0;
        cordic_ctl.angle = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_FILT_L;
            end
            S_FILT_L: begin
                mul_a   = {r_raw_l[15], r_raw_l, 16'h0} - {r_fl[31], r_fl};
                mul_b   = {15'h0, r_gain};
                n_state = S_FILT_R;
            end
            S_FILT_R: begin
                mul_a   = {r_raw_r[15], r_raw_r, 16'h0} - {r_fr[31], r_fr};
                mul_b   = {15'h0, r_gain};
                n_state = S_SUM;
            end
            S_SUM: begin
                cordic_ctl.start = 1'b1;
                n_state          = S_DIST;
            end
            S_DIST: begin
                mul_a   = {r_fl[31], r_fl} + {r_fr[31], r_fr};
                mul_b   = {7'h0, r_lin};
                n_state = S_CORD;
            end
            S_CORD: begin
                // keep the distance product steady while the CORDIC runs
                mul_a   = {r_fl[31], r_fl} + {r_fr[31], r_fr};
                mul_b   = {7'h0, r_lin};
                if (!cordic_busy) n_state = S_DX;
            end
            S_DX: begin
                mul_a   = r_d;
                mul_b   = cos_v[30:0];
                n_state = S_DY;
            end
            S_DY: begin
                mul_a   = r_d;
                mul_b   = sin_v[30:0];
                n_state = S_DH;
            end
            S_DH: begin
                mul_a   = {r_fr[31], r_fr} - {r_fl[31], r_fl};
                mul_b   = {7'h0, r_ang};
                n_state = S_HEAD;
            end
            S_HEAD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RST;
            r_lin  <= LIN_RST;
            r_ang  <= ANG_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FILTER_GAIN:   r_gain <= i_cfg_data[15:0];
                CFG_LINEAR_SCALE:  r_lin  <= i_cfg_data;
                CFG_ANGULAR_SCALE: r_ang  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pose and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fl   <= '0;
            r_fr   <= '0;
            r_px   <= '0;
            r_py   <= '0;
            r_head <= '0;
        end else begin
            case (r_state)
                S_FILT_R: r_fl   <= r_fl + rnd16[31:0];
                S_SUM:    r_fr   <= r_fr + rnd16[31:0];
                S_DY:     r_px   <= r_px + rnd28[47:0];
                S_DH:     r_py   <= r_py + rnd28[47:0];
                S_HEAD:   r_head <= r_head + rnd16[31:0];
                default: ;
            endcase
        end
    end

    // input capture and distance hold
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_raw_l <= i_in_data.left_tick_rate;
            r_raw_r <= i_in_data.right_tick_rate;
        end
        if (r_state == S_CORD) begin
            r_d <= rnd24[32:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out.pose_x         <= r_px;
            r_out.pose_y         <= r_py;
            r_out.heading        <= r_head;
            r_out.smoothed_left  <= r_fl;
            r_out.smoothed_right <= r_fr;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;
endmodule

@@ bench/diff_drive_odometry_test.sv @@
// Testbench for diff_drive_odometry: random and directed wheel rates, with a
// scoreboard that predicts pose, heading and filtered rates for each beat.
// Depends on ddo_pkg and the diff_drive_odometry RTL.
`timescale 1ns / 1ps

module diff_drive_odometry_test;
    import ddo_pkg::*;

    // Pose predictor and queue of expected output beats
    class odometry_scoreboard;
        t_out_beat        pending_poses[$];
        int               mismatches;
        logic [15:0]      gain;
        logic [23:0]      lin_scale;
        logic [23:0]      ang_scale;
        logic signed [31:0] filt_l, filt_r;
        logic [47:0]      pos_x, pos_y;
        logic [31:0]      head;

        function new();
            mismatches = 0;
            gain = GAIN_RST;
            lin_scale = LIN_RST;
            ang_scale = ANG_RST;
            filt_l = 0;
            filt_r = 0;
            pos_x = 0;
            pos_y = 0;
            head = 0;
        endfunction

        // Round half up of v / 2^s; >>> on signed longint floors
        function longint rnd(longint v, int s);
            longint b;
            b = longint'(1) <<< (s - 1);
            return (v + b) >>> s;
        endfunction

        function logic signed [31:0] smooth(logic signed [31:0] f, logic signed [15:0] raw);
            longint diff;
            diff = longint'(raw) * 65536 - longint'(f);
            return 32'(longint'(f) + rnd(longint'({1'b0, gain}) * diff, 16));
        endfunction

        // Rotation-mode CORDIC, cos and sin in Q.28
        function void rotate(logic [31:0] ang, output longint c, output longint s);
            logic [31:0] u;
            logic        flip;
            longint      x, y, z, xs, ys;
            u = ang;
            flip = 1'b0;
            if (((u + 32'h4000_0000) & 32'h8000_0000) != 0) begin
                u = u + 32'h8000_0000;
                flip = 1'b1;
            end
            z = longint'($signed(u));
            x = 163008219;
            y = 0;
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(ATAN_TAB[i]);
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(ATAN_TAB[i]);
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void set_reg(logic [7:0] idx, logic [23:0] val);
            case (idx)
                CFG_FILTER_GAIN:   gain = val[15:0];
                CFG_LINEAR_SCALE:  lin_scale = val;
                CFG_ANGULAR_SCALE: ang_scale = val;
                default: ;
            endcase
        endfunction

        // Note an accepted input beat and queue its pose
        function void note_rates(t_in_beat b);
            longint    d, c, s, dh;
            t_out_beat e;
            filt_l = smooth(filt_l, b.left_tick_rate);
            filt_r = smooth(filt_r, b.right_tick_rate);
            d = rnd((longint'(filt_l) + longint'(filt_r)) * longint'({1'b0, lin_scale}), 24);
            rotate(head, c, s);
            pos_x = pos_x + 48'(rnd(d * c, 28));
            pos_y = pos_y + 48'(rnd(d * s, 28));
            dh = rnd((longint'(filt_r) - longint'(filt_l)) * longint'({1'b0, ang_scale}), 16);
            head = head + 32'(dh);
            e.pose_x = pos_x;
            e.pose_y = pos_y;
            e.heading = head;
            e.smoothed_left = filt_l;
            e.smoothed_right = filt_r;
            pending_poses.push_back(e);
        endfunction

        function void check_pose(t_out_beat a);
            t_out_beat e;
            if (pending_poses.size() == 0) begin
                $error("output beat with none expected");
                mismatches++;
                return;
            end
            e = pending_poses.pop_front();
            if (a.pose_x !== e.pose_x) begin
                $error("pose_x exp %0d got %0d", e.pose_x, a.pose_x);
                mismatches++;
            end
            if (a.pose_y !== e.pose_y) begin
                $error("pose_y exp %0d got %0d", e.pose_y, a.pose_y);
                mismatches++;
            end
            if (a.heading !== e.heading) begin
                $error("heading exp %0d got %0d", e.heading, a.heading);
                mismatches++;
            end
            if (a.smoothed_left !== e.smoothed_left) begin
                $error("smoothed_left exp %0d got %0d", e.smoothed_left, a.smoothed_left);
                mismatches++;
            end
            if (a.smoothed_right !== e.smoothed_right) begin
                $error("smoothed_right exp %0d got %0d", e.smoothed_right, a.smoothed_right);
                mismatches++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_beat   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_beat  o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    odometry_scoreboard odo;
    bit                 stim_done = 1'b0;

    diff_drive_odometry DUT (.*);

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, sometimes long ones, sometimes none
    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Valid drops between beats; the block's own stall is longer than the shortest gap
    task automatic send_rates(logic signed [15:0] l, logic signed [15:0] r);
        repeat (gap_len() + 1) @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= '{left_tick_rate: l, right_tick_rate: r};
        do @(posedge i_clk); while (o_in_stall);
        odo.note_rates(i_in_data);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic write_reg(logic [7:0] idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        odo.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every pose has come back, then a margin
    task automatic drain();
        while (odo.pending_poses.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic random_rates(int n, int span);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_rates(16'($urandom), 16'($urandom));
            else
                send_rates(16'($signed($urandom_range(0, 2 * span)) - span),
                           16'($signed($urandom_range(0, 2 * span)) - span));
        end
    endtask

    // Output side: random stall, check each accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            odo.check_pose(o_out_data);
    end

    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            g = gap_len();
            if (g != 0) begin
                i_out_stall <= 1'b1;
                repeat (g - 1) @(negedge i_clk);
                @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Main stimulus
    initial begin
        odo = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes and sign mixes under reset settings
        send_rates(16'sh7fff, 16'sh7fff);
        send_rates(-16'sh8000, -16'sh8000);
        send_rates(16'sh7fff, -16'sh8000);
        send_rates(-16'sh8000, 16'sh7fff);
        send_rates(0, 0);
        send_rates(16'sh5555, -16'sh2aab);
        send_rates(-1, 1);
        send_rates(100, 300);
        drain();
        // Zero gain: filters hold
        write_reg(CFG_FILTER_GAIN, 24'd0);
        send_rates(16'sh1234, -16'sh4321);
        send_rates(-16'sh8000, 16'sh7fff);
        drain();
        // Full gain, max scales: large heading and position steps
        write_reg(CFG_FILTER_GAIN, 24'hffff);
        write_reg(CFG_LINEAR_SCALE, 24'hffffff);
        write_reg(CFG_ANGULAR_SCALE, 24'hffffff);
        write_reg(8'd3, 24'h123456);
        write_reg(8'hff, 24'hffffff);
        send_rates(16'sh7fff, 16'sh7fff);
        send_rates(-16'sh8000, 16'sh7fff);
        send_rates(16'sh7fff, -16'sh8000);
        send_rates(16'sh4000, 16'sh3000);
        drain();
        write_reg(CFG_LINEAR_SCALE, 24'd0);
        write_reg(CFG_ANGULAR_SCALE, 24'd0);
        send_rates(16'sh7000, -16'sh7000);
        drain();

        // Random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_FILTER_GAIN, 24'($urandom_range(0, 65535)));
            write_reg(CFG_LINEAR_SCALE, 24'($urandom));
            write_reg(CFG_ANGULAR_SCALE, 24'($urandom));
            random_rates(120, (ph % 2) ? 32767 : 500);
            drain();
        end
        write_reg(CFG_FILTER_GAIN, GAIN_RST);
        write_reg(CFG_LINEAR_SCALE, LIN_RST);
        write_reg(CFG_ANGULAR_SCALE, ANG_RST);
        random_rates(20, 32767);
        drain();
        stim_done = 1'b1;
    end

    // End of run
    initial begin
        wait (stim_done);
        if (odo.mismatches == 0 && odo.pending_poses.size() == 0)
            $display("diff_drive_odometry_test passed");
        else
            $display("diff_drive_odometry_test failed");
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("diff_drive_odometry_test failed");
        $finish;
    end

endmodule
